### rtl/svts_pkg.sv
// shared constants, codes and types of the six-voice tune synthesiser
package svts_pkg;

    localparam int VOICES          = 6;
    localparam int STORE_DEPTH_DEF = 2048;
    localparam int TUNE_STEPS      = 96;
    localparam int TUNE_STRIDE     = 576;
    localparam int NOTE_TUNE       = 4;
    localparam int LAST_NOTE       = 12;
    localparam int FREQ_SHIFT      = 10;
    localparam int DIV_W           = 24;
    localparam int SR_W            = 16;
    localparam int WORD_W          = 15;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 60;

    localparam logic [14:0] VOL_MAX     = 15'h7fff;
    localparam logic [15:0] SR_RESET    = 16'd44100;
    localparam logic [14:0] SPEED_RESET = 15'd32767;

    typedef enum logic [2:0] {
        ACT_TICK   = 3'd0,
        ACT_TUNE   = 3'd1,
        ACT_NOTE   = 3'd2,
        ACT_ENABLE = 3'd3,
        ACT_STORE  = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        CFG_SAMPLE_RATE = 3'd0,
        CFG_BASE_FREQ   = 3'd1,
        CFG_TUNE_SPEED  = 3'd2,
        CFG_DECAY_LOW   = 3'd3,
        CFG_DECAY_HIGH  = 3'd4
    } t_cfg_index;

    typedef enum logic [4:0] {
        S_IDLE,
        S_VOL,
        S_VOL_DIV,
        S_VOL_MUL,
        S_VOL_ADD,
        S_TEMPO,
        S_TEMPO_DIV,
        S_RD_ADDR,
        S_RD_WAIT,
        S_FREQ_SET,
        S_TONE,
        S_TONE_DIV,
        S_MIX,
        S_MIX_WAIT,
        S_OUT
    } t_state;

endpackage

### rtl/svts_ram.sv
// generic single-port-write, registered-read memory
module svts_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/svts_div.sv
// shared restoring divider, one quotient bit per cycle
module svts_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [svts_pkg::DIV_W-1:0] i_dividend,
    input  logic [svts_pkg::SR_W-1:0]  i_divisor,
    output logic                      o_done,
    output logic [svts_pkg::DIV_W-1:0] o_quotient,
    output logic [svts_pkg::SR_W-1:0]  o_remainder
);

    localparam int DW = svts_pkg::DIV_W;
    localparam int RW = svts_pkg::SR_W;
    localparam int CW = $clog2(DW);

    logic          r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_q;
    logic [RW-1:0] r_rem, r_d;
    logic [RW:0]   w_trial;
    logic          w_fit;

    assign w_trial = {r_rem, r_q[DW-1]};
    assign w_fit   = w_trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DW-2:0], w_fit};
            r_rem <= w_fit ? RW'(w_trial - {1'b0, r_d}) : w_trial[RW-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_q;
    assign o_remainder = r_rem;

endmodule

### rtl/six_voice_tune_synth_unit.sv
// top level of the six-voice tune synthesiser: sequencer, voice state and mixer
// A silent sample tick goes straight to the output state. Otherwise each voice whose
// volume or tone divider wraps runs a division on the single shared divider (24 quotient
// bits), as do the tempo counter wrap and the final mix division; a run-out volume adds
// a multiply and an add step; a new note adds one store read per voice and a step for
// each voice restarted, and an output stall holds the tick. Other actions are taken in
// the idle state. The input stalls while a tick is worked on; one finished sample may
// wait in the output register while the next item enters.
module six_voice_tune_synth_unit #(
    parameter int STORE_DEPTH = svts_pkg::STORE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_action,
    input  logic [1:0]  i_tune_number,
    input  logic [1:0]  i_octave,
    input  logic [3:0]  i_note,
    input  logic [5:0]  i_enable_mask,
    input  logic [10:0] i_store_address,
    input  logic [14:0] i_store_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [14:0] o_sample,
    input  logic        i_cfg_we,
    input  logic [svts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [svts_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int NV = svts_pkg::VOICES;

    svts_pkg::t_state r_state, n_state;

    logic [15:0] r_sr;
    logic [12:0] r_base;
    logic [14:0] r_speed;
    logic [59:0] r_dlo;
    logic [29:0] r_dhi;

    logic [14:0]        r_vol  [NV];
    logic signed [16:0] r_vdiv [NV];
    logic signed [24:0] r_tdiv [NV];
    logic [23:0]        r_freq [NV];
    logic [14:0]        n_vol  [NV];
    logic signed [16:0] n_vdiv [NV];
    logic signed [24:0] n_tdiv [NV];
    logic [23:0]        n_freq [NV];

    logic [5:0]         r_outb, n_outb, r_en, n_en;
    logic [2:0]         r_act, n_act, r_tune, n_tune, r_v, n_v;
    logic signed [17:0] r_tempo, n_tempo;
    logic signed [16:0] r_note, n_note;
    logic [6:0]         r_step, n_step, r_lim, n_lim;
    logic [1:0]         r_oct, n_oct;
    logic signed [25:0] r_c, n_c;
    logic [17:0]        r_sum, n_sum;
    logic [31:0]        r_prod, n_prod;
    logic [14:0]        r_mix, n_mix, r_sample, n_sample;
    logic               r_out_valid, n_out_valid, r_addr_ok, n_addr_ok;

    // shared units
    logic        w_div_start, w_div_done;
    logic [23:0] w_div_a, w_q;
    logic [15:0] w_div_b, w_r, w_mul_a, w_mul_b;
    logic [31:0] w_mul_p;

    logic [15:0]        w_sr;
    logic [89:0]        w_decay_all;
    logic [14:0]        w_decay, w_word;
    logic signed [25:0] w_cvol, w_t, w_tc, w_nn;
    logic [24:0]        w_q1;
    logic [16:0]        w_sr_r;
    logic [12:0]        w_raddr_full;
    logic [AW-1:0]      w_raddr;
    logic               w_in_acc, w_last, w_out_free, w_sil, w_tone_on, w_newbit;
    logic               w_ram_we;
    logic [14:0]        w_rdata;

    assign w_sr        = (r_sr == '0) ? 16'd1 : r_sr;
    assign w_decay_all = {r_dhi, r_dlo};
    assign w_decay     = w_decay_all[r_v * 15 +: 15];
    assign w_cvol      = 26'(r_vdiv[r_v]) - 26'(signed'({1'b0, w_decay}));
    assign w_t         = 26'(r_tempo) - 26'(signed'({1'b0, r_speed}));
    assign w_tc        = 26'(r_tdiv[r_v]) - 26'(signed'({1'b0, r_freq[r_v]}));
    assign w_q1        = {1'b0, w_q} + 25'd1;
    assign w_nn        = 26'(r_note) - 26'(signed'({1'b0, w_q1}));
    assign w_sr_r      = {1'b0, w_sr} - {1'b0, w_r};
    assign w_in_acc    = i_in_valid && (r_state == svts_pkg::S_IDLE);
    assign w_last      = (r_v == 3'(NV - 1));
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_sil       = (r_tune == '0) || (r_act == '0);
    assign w_tone_on   = r_en[r_v] && (r_freq[r_v] != '0);
    assign w_newbit    = r_outb[r_v] ^ !w_q[0];
    assign w_word      = r_addr_ok ? w_rdata : '0;
    assign w_mul_p     = w_mul_a * w_mul_b;

    assign w_raddr_full = 13'((r_tune - 3'd1) * svts_pkg::TUNE_STRIDE)
                        + 13'(r_step * 6) + 13'(r_v);
    assign w_raddr      = w_raddr_full[AW-1:0];
    assign w_ram_we     = w_in_acc && (i_action == svts_pkg::ACT_STORE)
                        && (32'(i_store_address) < STORE_DEPTH);

    svts_ram #(.WIDTH(svts_pkg::WORD_W), .DEPTH(STORE_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (AW'(i_store_address)),
        .i_wdata (i_store_data),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    svts_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_div_a),
        .i_divisor   (w_div_b),
        .o_done      (w_div_done),
        .o_quotient  (w_q),
        .o_remainder (w_r)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            svts_pkg::S_IDLE: begin
                if (w_in_acc && (i_action == svts_pkg::ACT_TICK)) begin
                    n_state = w_sil ? svts_pkg::S_OUT : svts_pkg::S_VOL;
                end
            end
            svts_pkg::S_VOL: begin
                if (r_vol[r_v] != '0 && w_cvol <= 0) begin
                    n_state = svts_pkg::S_VOL_DIV;
                end else if (w_last) begin
                    n_state = svts_pkg::S_TEMPO;
                end
            end
            svts_pkg::S_VOL_DIV: begin
                if (w_div_done) begin
                    if (w_q1 > 25'(r_vol[r_v])) begin
                        n_state = svts_pkg::S_VOL_MUL;
                    end else begin
                        n_state = w_last ? svts_pkg::S_TEMPO : svts_pkg::S_VOL;
                    end
                end
            end
            svts_pkg::S_VOL_MUL: n_state = svts_pkg::S_VOL_ADD;
            svts_pkg::S_VOL_ADD: n_state = w_last ? svts_pkg::S_TEMPO : svts_pkg::S_VOL;
            svts_pkg::S_TEMPO: begin
                n_state = (w_t > 0) ? svts_pkg::S_TONE : svts_pkg::S_TEMPO_DIV;
            end
            svts_pkg::S_TEMPO_DIV: begin
                if (w_div_done) begin
                    n_state = (w_nn <= 0 && r_step < r_lim) ? svts_pkg::S_RD_ADDR
                                                             : svts_pkg::S_TONE;
                end
            end
            svts_pkg::S_RD_ADDR: n_state = svts_pkg::S_RD_WAIT;
            svts_pkg::S_RD_WAIT: begin
                if (w_word != '0) begin
                    n_state = svts_pkg::S_FREQ_SET;
                end else begin
                    n_state = w_last ? svts_pkg::S_TONE : svts_pkg::S_RD_ADDR;
                end
            end
            svts_pkg::S_FREQ_SET: n_state = w_last ? svts_pkg::S_TONE : svts_pkg::S_RD_ADDR;
            svts_pkg::S_TONE: begin
                if (w_tone_on && w_tc <= 0) begin
                    n_state = svts_pkg::S_TONE_DIV;
                end else if (w_last) begin
                    n_state = svts_pkg::S_MIX;
                end
            end
            svts_pkg::S_TONE_DIV: begin
                if (w_div_done) begin
                    n_state = w_last ? svts_pkg::S_MIX : svts_pkg::S_TONE;
                end
            end
            svts_pkg::S_MIX:      n_state = svts_pkg::S_MIX_WAIT;
            svts_pkg::S_MIX_WAIT: n_state = w_div_done ? svts_pkg::S_OUT : svts_pkg::S_MIX_WAIT;
            svts_pkg::S_OUT:      n_state = w_out_free ? svts_pkg::S_IDLE : svts_pkg::S_OUT;
            default:              n_state = svts_pkg::S_IDLE;
        endcase
    end

    // datapath and unit controls
    always_comb begin
        n_vol  = r_vol;
        n_vdiv = r_vdiv;
        n_tdiv = r_tdiv;
        n_freq = r_freq;
        n_outb = r_outb;
        n_en   = r_en;
        n_act  = r_act;
        n_tune = r_tune;
        n_v    = r_v;
        n_tempo = r_tempo;
        n_note  = r_note;
        n_step  = r_step;
        n_lim   = r_lim;
        n_oct   = r_oct;
        n_c     = r_c;
        n_sum   = r_sum;
        n_prod  = r_prod;
        n_mix   = r_mix;
        n_addr_ok = r_addr_ok;
        n_sample  = r_sample;
        n_out_valid = r_out_valid && i_out_stall;
        w_div_start = 1'b0;
        w_div_a = 24'(-w_cvol);
        w_div_b = w_sr;
        w_mul_a = 16'(r_vol[r_v]) + 16'd1;
        w_mul_b = w_sr;

        case (r_state)
            svts_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    case (i_action)
                        svts_pkg::ACT_TICK: begin
                            n_sum = '0;
                            n_v   = '0;
                            n_mix = '0;
                        end
                        svts_pkg::ACT_TUNE: begin
                            if (3'(i_tune_number) != r_tune) begin
                                n_tune = 3'(i_tune_number);
                                n_step = '0;
                                n_lim  = 7'(svts_pkg::TUNE_STEPS);
                            end
                        end
                        svts_pkg::ACT_NOTE: begin
                            if (i_note <= 4'(svts_pkg::LAST_NOTE)) begin
                                n_tempo = '0;
                                n_note  = '0;
                                for (int v = 0; v < NV; v++) begin
                                    n_vdiv[v] = '0;
                                    n_tdiv[v] = '0;
                                end
                                n_oct  = i_octave;
                                n_tune = 3'(svts_pkg::NOTE_TUNE);
                                n_step = 7'(i_note);
                                n_lim  = 7'(i_note) + 7'd1;
                            end
                        end
                        svts_pkg::ACT_ENABLE: begin
                            if (i_enable_mask != r_en) begin
                                n_en  = i_enable_mask;
                                n_act = 3'($countones(i_enable_mask));
                            end
                        end
                        default: ;
                    endcase
                end
            end
            svts_pkg::S_VOL: begin
                if (r_vol[r_v] != '0) begin
                    if (w_cvol > 0) begin
                        n_vdiv[r_v] = 17'(w_cvol);
                    end else begin
                        n_c = w_cvol;
                        w_div_start = 1'b1;
                    end
                end
                if (r_vol[r_v] == '0 || w_cvol > 0) begin
                    n_v = w_last ? 3'd0 : r_v + 3'd1;
                end
            end
            svts_pkg::S_VOL_DIV: begin
                if (w_div_done && w_q1 <= 25'(r_vol[r_v])) begin
                    n_vdiv[r_v] = 17'(w_sr_r);
                    n_vol[r_v]  = r_vol[r_v] - 15'(w_q1);
                    n_v = w_last ? 3'd0 : r_v + 3'd1;
                end
            end
            svts_pkg::S_VOL_MUL: begin
                n_prod = w_mul_p;
            end
            svts_pkg::S_VOL_ADD: begin
                // volume ran out: land the divider past the last step
                n_vdiv[r_v] = 17'(34'(r_c) + 34'(signed'({2'b0, r_prod})));
                n_vol[r_v]  = '0;
                n_freq[r_v] = '0;
                n_v = w_last ? 3'd0 : r_v + 3'd1;
            end
            svts_pkg::S_TEMPO: begin
                if (w_t > 0) begin
                    n_tempo = 18'(w_t);
                end else begin
                    w_div_a = 24'(-w_t);
                    w_div_start = 1'b1;
                end
            end
            svts_pkg::S_TEMPO_DIV: begin
                if (w_div_done) begin
                    n_tempo = 18'(w_sr_r);
                    if (w_nn <= 0) begin
                        n_note = 17'(w_nn + 26'(svts_pkg::VOL_MAX));
                    end else begin
                        n_note = 17'(w_nn);
                    end
                end
            end
            svts_pkg::S_RD_ADDR: begin
                n_addr_ok = 32'(w_raddr_full) < STORE_DEPTH;
            end
            svts_pkg::S_RD_WAIT: begin
                w_mul_a = 16'(w_word);
                w_mul_b = 16'(r_base) << r_oct;
                if (w_word != '0) begin
                    n_prod = w_mul_p;
                end else begin
                    n_v = w_last ? 3'd0 : r_v + 3'd1;
                    if (w_last) begin
                        n_step = r_step + 7'd1;
                    end
                end
            end
            svts_pkg::S_FREQ_SET: begin
                n_freq[r_v] = 24'(r_prod >> svts_pkg::FREQ_SHIFT);
                n_vol[r_v]  = svts_pkg::VOL_MAX;
                n_v = w_last ? 3'd0 : r_v + 3'd1;
                if (w_last) begin
                    n_step = r_step + 7'd1;
                end
            end
            svts_pkg::S_TONE: begin
                w_div_a = 24'(-w_tc);
                if (w_tone_on && w_tc <= 0) begin
                    w_div_start = 1'b1;
                end else begin
                    if (w_tone_on) begin
                        n_tdiv[r_v] = 25'(w_tc);
                        if (r_outb[r_v]) begin
                            n_sum = r_sum + 18'(r_vol[r_v]);
                        end
                    end
                    n_v = w_last ? 3'd0 : r_v + 3'd1;
                end
            end
            svts_pkg::S_TONE_DIV: begin
                if (w_div_done) begin
                    // odd number of half periods flips the output
                    n_tdiv[r_v] = 25'(w_sr_r);
                    n_outb[r_v] = w_newbit;
                    if (w_newbit) begin
                        n_sum = r_sum + 18'(r_vol[r_v]);
                    end
                    n_v = w_last ? 3'd0 : r_v + 3'd1;
                end
            end
            svts_pkg::S_MIX: begin
                w_div_a = 24'(r_sum);
                w_div_b = 16'(r_act);
                w_div_start = 1'b1;
            end
            svts_pkg::S_MIX_WAIT: begin
                if (w_div_done) begin
                    n_mix = w_q[14:0];
                end
            end
            svts_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_sample    = r_mix;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= svts_pkg::S_IDLE;
            r_sr        <= svts_pkg::SR_RESET;
            r_base      <= '0;
            r_speed     <= svts_pkg::SPEED_RESET;
            r_dlo       <= '0;
            r_dhi       <= '0;
            r_outb      <= '0;
            r_en        <= '0;
            r_act       <= '0;
            r_tune      <= '0;
            r_v         <= '0;
            r_tempo     <= '0;
            r_note      <= '0;
            r_step      <= '0;
            r_lim       <= '0;
            r_oct       <= '0;
            r_out_valid <= 1'b0;
            for (int v = 0; v < NV; v++) begin
                r_vol[v]  <= '0;
                r_vdiv[v] <= '0;
                r_tdiv[v] <= '0;
                r_freq[v] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_outb      <= n_outb;
            r_en        <= n_en;
            r_act       <= n_act;
            r_tune      <= n_tune;
            r_v         <= n_v;
            r_tempo     <= n_tempo;
            r_note      <= n_note;
            r_step      <= n_step;
            r_lim       <= n_lim;
            r_oct       <= n_oct;
            r_out_valid <= n_out_valid;
            r_vol       <= n_vol;
            r_vdiv      <= n_vdiv;
            r_tdiv      <= n_tdiv;
            r_freq      <= n_freq;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    svts_pkg::CFG_SAMPLE_RATE: r_sr    <= i_cfg_data[15:0];
                    svts_pkg::CFG_BASE_FREQ:   r_base  <= i_cfg_data[12:0];
                    svts_pkg::CFG_TUNE_SPEED:  r_speed <= i_cfg_data[14:0];
                    svts_pkg::CFG_DECAY_LOW:   r_dlo   <= i_cfg_data[59:0];
                    svts_pkg::CFG_DECAY_HIGH:  r_dhi   <= i_cfg_data[29:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_c       <= n_c;
        r_sum     <= n_sum;
        r_prod    <= n_prod;
        r_mix     <= n_mix;
        r_addr_ok <= n_addr_ok;
        r_sample  <= n_sample;
    end

    assign o_in_stall  = (r_state != svts_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;

`ifndef SYNTHESIS
    a_tick_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_action == svts_pkg::ACT_TICK) |=> o_in_stall)
        else $error("input not held off after a tick transaction");

    a_active_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act == 3'($countones(r_en)))
        else $error("active voice count out of step with enables");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= r_lim)
        else $error("step offset past step limit");

    a_output_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == svts_pkg::S_OUT && w_out_free) |=> (o_out_valid && !o_in_stall))
        else $error("finished sample not presented");
`endif

endmodule
